>>> rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the script source tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int MaxIdent  = 32;
    localparam int MaxString = 256;
    localparam int KwDepth   = 6;
    localparam int QDepth    = 4;
    localparam int QAw       = 2;

    // token kinds
    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_NUMBER  = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_STRING  = 6'd3;
    localparam logic [5:0] K_AND     = 6'd4;
    localparam logic [5:0] K_OR      = 6'd5;
    localparam logic [5:0] K_IF      = 6'd6;
    localparam logic [5:0] K_ELSE    = 6'd7;
    localparam logic [5:0] K_WHILE   = 6'd8;
    localparam logic [5:0] K_END     = 6'd9;
    localparam logic [5:0] K_DEF     = 6'd10;
    localparam logic [5:0] K_RETURN  = 6'd11;
    localparam logic [5:0] K_PRINT   = 6'd12;
    localparam logic [5:0] K_PLUS    = 6'd13;
    localparam logic [5:0] K_MINUS   = 6'd14;
    localparam logic [5:0] K_STAR    = 6'd15;
    localparam logic [5:0] K_SLASH   = 6'd16;
    localparam logic [5:0] K_DOT     = 6'd17;
    localparam logic [5:0] K_COMMA   = 6'd18;
    localparam logic [5:0] K_LPAREN  = 6'd19;
    localparam logic [5:0] K_RPAREN  = 6'd20;
    localparam logic [5:0] K_LBRACK  = 6'd21;
    localparam logic [5:0] K_RBRACK  = 6'd22;
    localparam logic [5:0] K_LBRACE  = 6'd23;
    localparam logic [5:0] K_RBRACE  = 6'd24;
    localparam logic [5:0] K_EQEQ    = 6'd25;
    localparam logic [5:0] K_NE      = 6'd26;
    localparam logic [5:0] K_ASSIGN  = 6'd27;
    localparam logic [5:0] K_GE      = 6'd28;
    localparam logic [5:0] K_GT      = 6'd29;
    localparam logic [5:0] K_LE      = 6'd30;
    localparam logic [5:0] K_LT      = 6'd31;
    localparam logic [5:0] K_COLON   = 6'd32;
    localparam logic [5:0] K_UNKNOWN = 6'd33;

    // error codes
    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_ID_LONG  = 2'd1;
    localparam logic [1:0] E_STR_LONG = 2'd2;
    localparam logic [1:0] E_STR_OPEN = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_LCOMMENT, S_SLASH, S_BCOMMENT, S_BSTAR, S_NUMBER, S_IDENT,
        S_IDSKIP, S_STRING, S_STRESC, S_STRSKIP, S_SKIPESC, S_EQ, S_LT, S_GT
    } t_mode;

    // one result item
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] num;
        logic [7:0]  ch;
        logic        tv;
        logic        done;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } t_res;

    // up to three results caused by one byte
    typedef struct packed {
        logic [1:0] cnt;
        t_res [2:0] r;
    } t_bundle;

    function automatic logic [5:0] single_op(input logic [7:0] c);
        unique case (c)
            8'h2B: single_op = K_PLUS;
            8'h2D: single_op = K_MINUS;
            8'h2A: single_op = K_STAR;
            8'h2E: single_op = K_DOT;
            8'h2C: single_op = K_COMMA;
            8'h28: single_op = K_LPAREN;
            8'h29: single_op = K_RPAREN;
            8'h5B: single_op = K_LBRACK;
            8'h5D: single_op = K_RBRACK;
            8'h7B: single_op = K_LBRACE;
            8'h7D: single_op = K_RBRACE;
            8'h3A: single_op = K_COLON;
            default: single_op = K_UNKNOWN;
        endcase
    endfunction

    function automatic logic ident_start(input logic [7:0] c);
        ident_start = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || c == 8'h5F || c[7];
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        dec_digit = c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

>>> rtl/core/script_source_tokenizer.sv
// ----------------------------------------------------------------------------
// script_source_tokenizer
// Byte-stream lexer: scanner, bundle queue and result emitter.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// s_axis    in   source_byte[7:0]                        -
// m_axis    out  kind,num,char,valid,done,line,err (72b) -
// tlast on m_axis marks the last result of one byte
// one byte accepted per cycle while the queue has room; the scanner is
// combinational. the emitter sends one result per cycle while tready is
// high, so a byte's results go out in turn. the 4-deep queue decouples the
// sides. synchronous active-low reset returns line count to one.
module script_source_tokenizer import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // source_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // token_kind[5:0] number_value[37:6] text_char[45:38] text_valid[46]
    // token_done[47] line_at_token[63:48] error_code[65:64]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic    push, room, qv, pop;
    t_bundle fb, qb;
    t_res    res;

    sst_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid),
        .i_byte(s_axis_tdata), .o_ready(s_axis_tready), .o_push(push),
        .o_bundle(fb), .i_room(room));
    sst_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_bundle(fb),
        .o_room(room), .o_valid(qv), .o_bundle(qb), .i_pop(pop));
    sst_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .i_bundle(qb),
        .o_pop(pop), .o_tvalid(m_axis_tvalid), .o_res(res),
        .i_tready(m_axis_tready));

    assign m_axis_tdata = {6'd0, res.err, res.line, res.done, res.tv, res.ch,
                           res.num, res.kind};
    assign m_axis_tlast = res.last;
endmodule

>>> rtl/core/sst_front.sv
// ----------------------------------------------------------------------------
// sst_front
// Scanner: takes one byte per cycle while the queue has room, updates the mode and builds the results.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output logic        o_ready,
    output logic        o_push,
    output t_bundle     o_bundle,
    input  logic        i_room
);
    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [8:0]  r_len, n_len;
    logic [15:0] r_line, n_line;
    logic [7:0]  r_kw [KwDepth];
    logic        kw_we;
    logic [2:0]  kw_idx;
    t_bundle     b;
    logic [31:0] acc10;
    logic [5:0]  kwk;
    logic        go;

    assign o_ready = i_room;
    assign go      = i_valid && i_room;
    assign acc10   = (r_acc << 3) + (r_acc << 1) + {24'd0, i_byte - 8'h30};

    // keyword match over the short buffer
    always_comb begin
        kwk = K_IDENT;
        priority if (r_len == 9'd3 && r_kw[0] == 8'h61 && r_kw[1] == 8'h6E
                     && r_kw[2] == 8'h64) kwk = K_AND;
        else if (r_len == 9'd2 && r_kw[0] == 8'h6F && r_kw[1] == 8'h72)
            kwk = K_OR;
        else if (r_len == 9'd2 && r_kw[0] == 8'h69 && r_kw[1] == 8'h66)
            kwk = K_IF;
        else if (r_len == 9'd4 && r_kw[0] == 8'h65 && r_kw[1] == 8'h6C
                 && r_kw[2] == 8'h73 && r_kw[3] == 8'h65) kwk = K_ELSE;
        else if (r_len == 9'd5 && r_kw[0] == 8'h77 && r_kw[1] == 8'h68
                 && r_kw[2] == 8'h69 && r_kw[3] == 8'h6C && r_kw[4] == 8'h65)
            kwk = K_WHILE;
        else if (r_len == 9'd3 && r_kw[0] == 8'h65 && r_kw[1] == 8'h6E
                 && r_kw[2] == 8'h64) kwk = K_END;
        else if (r_len == 9'd3 && r_kw[0] == 8'h64 && r_kw[1] == 8'h65
                 && r_kw[2] == 8'h66) kwk = K_DEF;
        else if (r_len == 9'd6 && r_kw[0] == 8'h72 && r_kw[1] == 8'h65
                 && r_kw[2] == 8'h74 && r_kw[3] == 8'h75 && r_kw[4] == 8'h72
                 && r_kw[5] == 8'h6E) kwk = K_RETURN;
        else if (r_len == 9'd5 && r_kw[0] == 8'h70 && r_kw[1] == 8'h72
                 && r_kw[2] == 8'h69 && r_kw[3] == 8'h6E && r_kw[4] == 8'h74)
            kwk = K_PRINT;
        else kwk = K_IDENT;
    end

    // next mode and result items for one byte
    always_comb begin
        logic [7:0] c;
        logic       do_idle, do_str, do_skip;
        logic [7:0] sc;
        c = i_byte;
        n_mode = r_mode; n_acc = r_acc; n_len = r_len; n_line = r_line;
        kw_we = 1'b0; kw_idx = r_len[2:0];
        b = '0;
        do_idle = 1'b0; do_str = 1'b0; do_skip = 1'b0; sc = c;
        unique case (r_mode)
            S_IDLE: do_idle = 1'b1;
            S_LCOMMENT: begin
                if (c == 8'h0A) begin
                    if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                    n_mode = S_IDLE;
                end else if (c == 8'h00) do_idle = 1'b1;
            end
            S_SLASH: begin
                if (c == 8'h2A) n_mode = S_BCOMMENT;
                else begin
                    b.r[b.cnt] = '{kind: K_SLASH, done: 1'b1, line: r_line,
                                   default: '0};
                    b.cnt = b.cnt + 2'd1; do_idle = 1'b1;
                end
            end
            S_BCOMMENT: begin
                if (c == 8'h2A) n_mode = S_BSTAR;
                else if (c == 8'h00) do_idle = 1'b1;
            end
            S_BSTAR: begin
                if (c == 8'h2F) n_mode = S_IDLE;
                else if (c == 8'h00) do_idle = 1'b1;
                else if (c != 8'h2A) n_mode = S_BCOMMENT;
            end
            S_NUMBER: begin
                if (dec_digit(c)) n_acc = acc10;
                else begin
                    b.r[b.cnt] = '{kind: K_NUMBER, num: r_acc, done: 1'b1,
                                   line: r_line, default: '0};
                    b.cnt = b.cnt + 2'd1; do_idle = 1'b1;
                end
            end
            S_IDENT: begin
                if (ident_start(c) || dec_digit(c)) begin
                    kw_we = r_len < 9'(KwDepth);
                    n_len = r_len + 9'd1;
                    if (n_len >= 9'(MaxIdent)) begin
                        b.r[b.cnt] = '{kind: K_IDENT, done: 1'b1, line: r_line,
                                       err: E_ID_LONG, default: '0};
                        n_mode = S_IDSKIP;
                    end else
                        b.r[b.cnt] = '{kind: K_IDENT, ch: c, tv: 1'b1,
                                       line: r_line, default: '0};
                    b.cnt = b.cnt + 2'd1;
                end else begin
                    b.r[b.cnt] = '{kind: (r_len <= 9'(KwDepth)) ? kwk : K_IDENT,
                                   done: 1'b1, line: r_line, default: '0};
                    b.cnt = b.cnt + 2'd1; do_idle = 1'b1;
                end
            end
            S_IDSKIP: if (!(ident_start(c) || dec_digit(c))) do_idle = 1'b1;
            S_STRING: do_str = 1'b1;
            S_STRESC: begin
                n_mode = S_STRING;
                if (c == 8'h6E) sc = 8'h0A;
                else if (c == 8'h22 || c == 8'h5C) sc = c;
                else sc = 8'h5C;
                n_len = r_len + 9'd1;
                if (n_len >= 9'(MaxString)) begin
                    b.r[b.cnt] = '{kind: K_STRING, done: 1'b1, line: r_line,
                                   err: E_STR_LONG, default: '0};
                    n_mode = S_STRSKIP;
                end else
                    b.r[b.cnt] = '{kind: K_STRING, ch: sc, tv: 1'b1,
                                   line: r_line, default: '0};
                b.cnt = b.cnt + 2'd1;
                if (!(c == 8'h6E || c == 8'h22 || c == 8'h5C)) begin
                    if (n_mode == S_STRING) do_str = 1'b1;
                    else do_skip = 1'b1;
                end
            end
            S_STRSKIP: do_skip = 1'b1;
            S_SKIPESC: begin
                n_mode = S_STRSKIP;
                if (c == 8'h00) do_idle = 1'b1;
            end
            S_EQ: begin
                b.r[b.cnt] = '{kind: (c == 8'h3D) ? K_EQEQ : K_ASSIGN,
                               done: 1'b1, line: r_line, default: '0};
                b.cnt = b.cnt + 2'd1;
                if (c == 8'h3D) n_mode = S_IDLE; else do_idle = 1'b1;
            end
            S_LT: begin
                b.r[b.cnt] = '{kind: (c == 8'h3E) ? K_NE :
                               (c == 8'h3D) ? K_LE : K_LT,
                               done: 1'b1, line: r_line, default: '0};
                b.cnt = b.cnt + 2'd1;
                if (c == 8'h3E || c == 8'h3D) n_mode = S_IDLE;
                else do_idle = 1'b1;
            end
            S_GT: begin
                b.r[b.cnt] = '{kind: (c == 8'h3D) ? K_GE : K_GT,
                               done: 1'b1, line: r_line, default: '0};
                b.cnt = b.cnt + 2'd1;
                if (c == 8'h3D) n_mode = S_IDLE; else do_idle = 1'b1;
            end
            default: do_idle = 1'b1;
        endcase

        // string body byte
        if (do_str) begin
            if (c == 8'h00) begin
                b.r[b.cnt] = '{kind: K_STRING, done: 1'b1, line: r_line,
                               err: E_STR_OPEN, default: '0};
                b.cnt = b.cnt + 2'd1; do_idle = 1'b1;
            end else if (c == 8'h22) begin
                b.r[b.cnt] = '{kind: K_STRING, done: 1'b1, line: r_line,
                               default: '0};
                b.cnt = b.cnt + 2'd1; n_mode = S_IDLE;
            end else if (c == 8'h5C) n_mode = S_STRESC;
            else begin
                n_len = n_len + 9'd1;
                if (n_len >= 9'(MaxString)) begin
                    b.r[b.cnt] = '{kind: K_STRING, done: 1'b1, line: r_line,
                                   err: E_STR_LONG, default: '0};
                    n_mode = S_STRSKIP;
                end else
                    b.r[b.cnt] = '{kind: K_STRING, ch: c, tv: 1'b1,
                                   line: r_line, default: '0};
                b.cnt = b.cnt + 2'd1;
            end
        end

        // discarded string tail
        if (do_skip) begin
            if (c == 8'h00) do_idle = 1'b1;
            else if (c == 8'h22) n_mode = S_IDLE;
            else if (c == 8'h5C) n_mode = S_SKIPESC;
        end

        // idle handling of a byte
        if (do_idle) begin
            n_mode = S_IDLE;
            if (c == 8'h00) begin
                b.r[b.cnt] = '{kind: K_EOF, done: 1'b1, line: r_line,
                               default: '0};
                b.cnt = b.cnt + 2'd1;
            end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                if (c == 8'h0A && r_line != 16'hFFFF) n_line = r_line + 16'd1;
            end else if (c == 8'h23) n_mode = S_LCOMMENT;
            else if (c == 8'h2F) n_mode = S_SLASH;
            else if (dec_digit(c)) begin
                n_acc = {24'd0, c - 8'h30}; n_mode = S_NUMBER;
            end else if (ident_start(c)) begin
                kw_we = 1'b1; kw_idx = 3'd0; n_len = 9'd1; n_mode = S_IDENT;
                b.r[b.cnt] = '{kind: K_IDENT, ch: c, tv: 1'b1, line: r_line,
                               default: '0};
                b.cnt = b.cnt + 2'd1;
            end else if (c == 8'h22) begin
                n_len = 9'd0; n_mode = S_STRING;
            end else if (c == 8'h3D) n_mode = S_EQ;
            else if (c == 8'h3C) n_mode = S_LT;
            else if (c == 8'h3E) n_mode = S_GT;
            else begin
                b.r[b.cnt] = '{kind: single_op(c), done: 1'b1, line: r_line,
                               default: '0};
                b.cnt = b.cnt + 2'd1;
            end
        end

        // mark the last result of this byte
        if (b.cnt != 2'd0) b.r[b.cnt - 2'd1].last = 1'b1;

        // end of source returns all state to reset
        if (c == 8'h00) begin
            n_mode = S_IDLE; n_acc = '0; n_len = '0; n_line = 16'd1;
        end
    end

    assign o_push   = go && (b.cnt != 2'd0);
    assign o_bundle = b;

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_acc <= '0; r_len <= '0; r_line <= 16'd1;
        end else if (go) begin
            r_mode <= n_mode; r_acc <= n_acc; r_len <= n_len; r_line <= n_line;
        end
    end

    // keyword buffer, no reset
    always_ff @(posedge i_clk) begin
        if (go && kw_we) r_kw[kw_idx] <= i_byte;
    end

    ap_line_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0) else $error("line count zero");
    ap_eof_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && i_byte == 8'h00 |=> r_mode == S_IDLE && r_line == 16'd1)
        else $error("end of source did not reset");
    ap_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && i_byte == 8'h00 |-> o_push) else $error("no eof result");
endmodule

>>> rtl/core/sst_queue.sv
// ----------------------------------------------------------------------------
// sst_queue
// Short queue of result bundles between scanner and emitter.
// ----------------------------------------------------------------------------
module sst_queue import sst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_room,
    output logic    o_valid,
    output t_bundle o_bundle,
    input  logic    i_pop
);
    t_bundle          r_mem [QDepth];
    logic [QAw-1:0]   r_wp, r_rp;
    logic [QAw:0]     r_cnt;

    assign o_room   = r_cnt != (QAw+1)'(QDepth);
    assign o_valid  = r_cnt != '0;
    assign o_bundle = r_mem[r_rp];

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    ap_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room) else $error("queue overflow");
    ap_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
endmodule

>>> rtl/core/sst_back.sv
// ----------------------------------------------------------------------------
// sst_back
// Emitter: sends the results of one bundle one item per cycle while i_tready is high.
// ----------------------------------------------------------------------------
module sst_back import sst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_bundle i_bundle,
    output logic    o_pop,
    output logic    o_tvalid,
    output t_res    o_res,
    input  logic    i_tready
);
    logic [1:0] r_idx;
    logic       take, fin;

    assign o_tvalid = i_valid;
    assign o_res    = i_bundle.r[r_idx];
    assign take     = i_valid && i_tready;
    assign fin      = take && (r_idx + 2'd1 == i_bundle.cnt);
    assign o_pop    = fin;

    // index within bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= '0;
        else if (fin) r_idx <= '0;
        else if (take) r_idx <= r_idx + 2'd1;
    end

    ap_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> r_idx < i_bundle.cnt) else $error("index past bundle");
    ap_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> o_res.last) else $error("bundle end without last");
endmodule
